/* sv/trial_division_prime_test_defines.svh */
// Assertion macros shared by the trial-division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef ASSERT_OFF

`define TDPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TDPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TDPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define TDPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/tdpt_pkg.sv */
// Package with constants and types for the trial-division prime test.
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CAND_WIDTH      = 32;
    localparam int OUT_TDATA_WIDTH = 8;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PRE    = 6'b000010,
        ST_LAUNCH = 6'b000100,
        ST_WAIT   = 6'b001000,
        ST_TEST   = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_THREE = 3'b001,
        PH_LOW   = 3'b010,
        PH_HIGH  = 3'b100
    } phase_t;

endpackage

`default_nettype wire

/* sv/tdpt_rem_unit.sv */
// Radix-2 restoring remainder unit that retires one dividend bit per cycle.
`default_nettype none
`include "trial_division_prime_test_defines.svh"

module tdpt_rem_unit #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      rem
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (diff[VALUE_WIDTH])
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end
            else
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

    `TDPT_ASSERT_IMPL(a_busy_has_count, clk, rst_n, busy_reg, cnt_reg != '0)
    `TDPT_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg, !busy_reg && cnt_reg == '0)

endmodule

`default_nettype wire

/* sv/trial_division_prime_test.sv */
// Top level of the trial-division prime test with its control sequencer.
`default_nettype none
`include "trial_division_prime_test_defines.svh"

// The block tests one signed value per item and returns one flag that is high
// when the value is prime. The low VALUE_WIDTH bits of the input are the operand.
// Values of one or less are not prime, two and three are, even values are not.
// Otherwise one shared remainder unit divides the value by three and then by
// each pair d and d+2 for d = 5, 11, 17, ... while d*d stays at most the value.
// Each divisor pair first goes through a square test of d*d against the value.
// The block takes one item at a time and is not ready until its result has
// been taken.
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [tdpt_pkg::CAND_WIDTH-1:0]      s_tdata,  // candidate_value
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [tdpt_pkg::OUT_TDATA_WIDTH-1:0]      m_tdata   // is_prime, zeros
);

    localparam int SW = VALUE_WIDTH + 2;

    tdpt_pkg::state_t       state_reg, state_next;
    tdpt_pkg::phase_t       phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [SW-1:0]          sq_reg, sq_next;
    logic                   res_reg, res_next;
    logic [VALUE_WIDTH-1:0] operand;
    logic [VALUE_WIDTH-1:0] divisor;
    logic [SW-1:0]          d_wide;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_rem;

    generate
        if (VALUE_WIDTH > tdpt_pkg::CAND_WIDTH)
        begin : g_ext
            assign operand = {{(VALUE_WIDTH - tdpt_pkg::CAND_WIDTH){1'b0}}, s_tdata};
        end
        else if (VALUE_WIDTH == tdpt_pkg::CAND_WIDTH)
        begin : g_same
            assign operand = s_tdata;
        end
        else
        begin : g_cut
            assign operand = s_tdata[VALUE_WIDTH-1:0];
        end
    endgenerate

    always_comb
    begin
        case (phase_reg)
            tdpt_pkg::PH_THREE: divisor = VALUE_WIDTH'(3);
            tdpt_pkg::PH_LOW:   divisor = d_reg;
            tdpt_pkg::PH_HIGH:  divisor = d_reg + VALUE_WIDTH'(2);
            default:            divisor = VALUE_WIDTH'(3);
        endcase
    end

    assign d_wide    = {2'b00, d_reg};
    assign div_start = (state_reg == tdpt_pkg::ST_LAUNCH);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        res_next   = res_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    v_next     = operand;
                    state_next = tdpt_pkg::ST_PRE;
                end
            end
            tdpt_pkg::ST_PRE:
            begin
                if (v_reg[VALUE_WIDTH-1] || v_reg <= VALUE_WIDTH'(1))
                begin
                    res_next   = 1'b0;
                    state_next = tdpt_pkg::ST_OUT;
                end
                else if (v_reg <= VALUE_WIDTH'(3))
                begin
                    res_next   = 1'b1;
                    state_next = tdpt_pkg::ST_OUT;
                end
                else if (!v_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = tdpt_pkg::ST_OUT;
                end
                else
                begin
                    phase_next = tdpt_pkg::PH_THREE;
                    state_next = tdpt_pkg::ST_LAUNCH;
                end
            end
            tdpt_pkg::ST_LAUNCH:
            begin
                state_next = tdpt_pkg::ST_WAIT;
            end
            tdpt_pkg::ST_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = tdpt_pkg::ST_OUT;
                    end
                    else
                    begin
                        case (phase_reg)
                            tdpt_pkg::PH_THREE:
                            begin
                                d_next     = VALUE_WIDTH'(5);
                                sq_next    = SW'(25);
                                state_next = tdpt_pkg::ST_TEST;
                            end
                            tdpt_pkg::PH_LOW:
                            begin
                                phase_next = tdpt_pkg::PH_HIGH;
                                state_next = tdpt_pkg::ST_LAUNCH;
                            end
                            default:
                            begin
                                d_next     = d_reg + VALUE_WIDTH'(6);
                                sq_next    = sq_reg + (d_wide << 3) + (d_wide << 2)
                                           + SW'(36);
                                state_next = tdpt_pkg::ST_TEST;
                            end
                        endcase
                    end
                end
            end
            tdpt_pkg::ST_TEST:
            begin
                if (sq_reg <= {2'b00, v_reg})
                begin
                    phase_next = tdpt_pkg::PH_LOW;
                    state_next = tdpt_pkg::ST_LAUNCH;
                end
                else
                begin
                    res_next   = 1'b1;
                    state_next = tdpt_pkg::ST_OUT;
                end
            end
            tdpt_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdpt_pkg::ST_IDLE;
            phase_reg <= tdpt_pkg::PH_THREE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        res_reg <= res_next;
    end

    tdpt_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign s_tready = (state_reg == tdpt_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == tdpt_pkg::ST_OUT);
    assign m_tdata  = {{(tdpt_pkg::OUT_TDATA_WIDTH - 1){1'b0}}, res_reg};

    `TDPT_ASSERT_NEXT(a_accept_to_pre, clk, rst_n, s_tvalid && s_tready, state_reg == tdpt_pkg::ST_PRE)
    `TDPT_ASSERT_IMPL(a_prime_odd_or_two, clk, rst_n, m_tvalid && m_tdata[0], v_reg[0] || v_reg == VALUE_WIDTH'(2))
    `TDPT_ASSERT_IMPL(a_launch_unit_idle, clk, rst_n, div_start, !div_busy)
    `TDPT_ASSERT_IMPL(a_test_odd_divisor, clk, rst_n, state_reg == tdpt_pkg::ST_TEST, d_reg[0])

endmodule

`default_nettype wire

/* dv/trial_division_prime_test_test.sv */
`timescale 1ns / 1ps
// Testbench for the trial-division prime test: directed and random values checked by a scoreboard.
module trial_division_prime_test_test;

    localparam int     WIDTH           = tdpt_pkg::VALUE_WIDTH_DEF;
    localparam int     CAND_WIDTH      = tdpt_pkg::CAND_WIDTH;
    localparam int     OUT_TDATA_WIDTH = tdpt_pkg::OUT_TDATA_WIDTH;
    localparam int     ITEMS_PER_PHASE = 26;
    localparam int     HOLD_CYCLES     = 20_000;
    localparam int     DRAIN_CYCLES    = 200;
    localparam int     MAX_WIDE_ODD    = 4;
    localparam longint CYCLE_LIMIT     = 10_000_000;

    class prime_scoreboard;
        bit expected_flags[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function bit prime_flag(logic [CAND_WIDTH-1:0] raw);
            logic [WIDTH-1:0] operand;
            longint unsigned  v;
            longint unsigned  d;
            operand = raw[WIDTH-1:0];
            if (operand[WIDTH-1])
                return 1'b0;
            v = operand;
            if (v <= 1)
                return 1'b0;
            if (v <= 3)
                return 1'b1;
            if (v % 2 == 0 || v % 3 == 0)
                return 1'b0;
            for (d = 5; d * d <= v; d += 6)
            begin
                if (v % d == 0 || v % (d + 2) == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [CAND_WIDTH-1:0] value);
            expected_flags = {expected_flags, prime_flag(value)};
        endfunction

        function void check_flag(logic actual);
            bit want;
            if (expected_flags.size() == 0)
            begin
                $error("is_prime: unexpected result, expected none, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_flags.pop_front();
            if (actual !== want)
            begin
                $error("is_prime: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic [CAND_WIDTH-1:0]      s_tdata  = '0;
    logic                       m_tready = 1'b0;
    logic                       s_tready;
    logic                       m_tvalid;
    logic [OUT_TDATA_WIDTH-1:0] m_tdata;

    int     tx_idle_pct   = 24;
    int     rx_idle_pct   = 88;
    logic   hold_go       = 1'b0;
    logic   hold_seen     = 1'b0;
    int     hold_cnt      = 0;
    int     wide_odd_sent = 0;
    longint cycles        = 0;

    prime_scoreboard sb = new();

    logic [CAND_WIDTH-1:0] corner_values[22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd23, 32'd25,
        32'd35, 32'd49, 32'd121, 32'd143, 32'd289, 32'd65521, 32'd65537,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD
    };

    trial_division_prime_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The long hold-off keeps a finished result waiting so that the input stalls behind it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_flag(m_tdata[0]);
            if (hold_go && !hold_seen)
            begin
                hold_seen <= 1'b1;
                hold_cnt  <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [CAND_WIDTH-1:0] random_candidate();
        int                    pick;
        logic [CAND_WIDTH-1:0] value;
        pick = $urandom_range(99);
        if (pick < 50)
            value = $urandom_range(65535);
        else if (pick < 65)
            value = $urandom_range(1 << 20);
        else if (pick < 78)
            value = $urandom | 32'h8000_0000;
        else if (pick < 90)
            value = $urandom & 32'h7FFF_FFFE;
        else if (wide_odd_sent < MAX_WIDE_ODD)
        begin
            wide_odd_sent++;
            value = ($urandom & 32'h7FFF_FFFF) | 32'h1;
        end
        else
            value = $urandom_range(4095);
        return value;
    endfunction

    task automatic send_candidate(logic [CAND_WIDTH-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_candidate(value);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            send_candidate(corner_values[i]);
        repeat (ITEMS_PER_PHASE) send_candidate(random_candidate());
        wait_for_results();

        tx_idle_pct <= 88;
        rx_idle_pct <= 24;
        @(posedge clk);
        repeat (ITEMS_PER_PHASE) send_candidate(random_candidate());
        wait_for_results();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_go     <= 1'b1;
        @(posedge clk);
        repeat (ITEMS_PER_PHASE) send_candidate(random_candidate());
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
